// File: src/assert_macros.svh
// assertion macros shared by the rtl
// needs a clock named aclk and an active-low reset named aresetn in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: src/lus_pkg.sv
// types, constants and fixed-point helpers of the lu solver
// no dependencies
package lus_pkg;

    localparam int MAX_UNKNOWNS  = 16;
    localparam int FRACTION_BITS = 16;
    localparam int STORE_DEPTH   = MAX_UNKNOWNS * (MAX_UNKNOWNS + 1);
    localparam int MAT_AW        = $clog2(STORE_DEPTH);
    localparam int SOL_AW        = $clog2(MAX_UNKNOWNS);
    localparam int SIZE_W        = $clog2(MAX_UNKNOWNS + 1);
    localparam int CNT_W         = $clog2(STORE_DEPTH + 1);
    localparam int DVD_W         = 32 + FRACTION_BITS;
    localparam int DCNT_W        = $clog2(DVD_W);
    localparam int SIZE_RESET    = 4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SINGULAR = 2'd1;
    localparam logic [1:0] ST_SATURATE = 2'd2;

    typedef enum logic [14:0] {
        S_LOAD  = 15'b000000000000001,
        S_INIT  = 15'b000000000000010,
        S_INITW = 15'b000000000000100,
        S_RDA   = 15'b000000000001000,
        S_RDB   = 15'b000000000010000,
        S_MUL   = 15'b000000000100000,
        S_ACC   = 15'b000000001000000,
        S_FIN   = 15'b000000010000000,
        S_PIV   = 15'b000000100000000,
        S_DIV   = 15'b000001000000000,
        S_DWR   = 15'b000010000000000,
        S_NEXT  = 15'b000100000000000,
        S_ORD   = 15'b001000000000000,
        S_OWAIT = 15'b010000000000000,
        S_OHOLD = 15'b100000000000000
    } state_t;

    typedef enum logic [3:0] {
        PH_U = 4'b0001,
        PH_L = 4'b0010,
        PH_F = 4'b0100,
        PH_B = 4'b1000
    } phase_t;

    // round to nearest, ties up, on the product
    function automatic logic signed [63:0] round_q(input logic signed [63:0] p);
        return (p + (64'sd1 <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS;
    endfunction

    // bit 32 flags a clamp
    function automatic logic [32:0] sat_q(input logic signed [63:0] v);
        if (v > 64'sh000000007FFFFFFF) begin
            return {1'b1, 32'h7FFFFFFF};
        end else if (v < 64'shFFFFFFFF80000000) begin
            return {1'b1, 32'h80000000};
        end
        return {1'b0, v[31:0]};
    endfunction

endpackage

// File: src/lu_linear_system_solver_unit.sv
// lu solver: loads one word per cycle, then factors and solves from the store
// a multiply-accumulate steps through S_RDA, S_RDB, S_MUL and S_ACC on the
// single matrix read port, a division yields one quotient bit per cycle in
// S_DIV, and a result goes out through S_ORD, S_OWAIT and S_OHOLD
// reset clears control state only; matrix and solution stores are not cleared
// uses lus_pkg, lus_ram and assert_macros.svh
`include "assert_macros.svh"
module lu_linear_system_solver_unit
    import lus_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [4:0]          cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [31:0]  s_coefficient,
    input  logic                s_last_entry,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [31:0]  m_solution_value,
    output logic [3:0]          m_solution_index,
    output logic [1:0]          m_status,
    output logic                m_last_result
);

    state_t state_reg, state_next;
    phase_t phase_reg;

    logic [SIZE_W-1:0] size_reg, n_reg, i_reg, j_reg, t_reg;
    logic [SIZE_W-1:0] act_size, thi, tlo;
    logic [SOL_AW-1:0] oi_reg;
    logic [CNT_W-1:0]  load_cnt_reg;
    logic [2*SIZE_W-1:0] total;
    logic sat_reg, neg_reg, is_div, is_sol_b, accept;
    logic piv_zero_reg, piv_singular;

    logic signed [63:0] acc_reg, prod_reg, prod_next, quo_s;
    logic signed [31:0] a_reg, val_reg, b_data, init_data;
    logic [31:0]        dmag_reg;
    logic [31:0]        rem_reg;
    logic [32:0]        rem_sh, acc_sat, quo_sat;
    logic [DVD_W-1:0]   dvd_reg, quo_reg;
    logic [DCNT_W-1:0]  dcnt_reg;

    logic [SIZE_W-1:0]   row_sel, col_sel;
    logic [2*SIZE_W-1:0] addr_calc;
    logic [MAT_AW-1:0]   mat_addr;
    logic [31:0]         mat_wdata, mat_rdata, sol_wdata, sol_rdata;
    logic                mat_we, sol_we;
    logic [SOL_AW-1:0]   sol_addr;

    logic signed [31:0] out_value_reg;
    logic [3:0]         out_index_reg;
    logic [1:0]         out_status_reg;
    logic               out_last_reg, out_valid_reg;

    assign act_size = (size_reg == '0) ? SIZE_W'(1)
                    : (size_reg > SIZE_W'(MAX_UNKNOWNS)) ? SIZE_W'(MAX_UNKNOWNS) : size_reg;
    assign total    = (2*SIZE_W)'(act_size) * (2*SIZE_W)'(act_size + SIZE_W'(1));
    assign s_ready  = (state_reg == S_LOAD);
    assign accept   = s_valid && s_ready;
    assign is_div   = (phase_reg == PH_L) || (phase_reg == PH_B);
    assign is_sol_b = (phase_reg == PH_F) || (phase_reg == PH_B);
    assign thi      = (phase_reg == PH_B) ? n_reg : i_reg;
    assign tlo      = (phase_reg == PH_B) ? i_reg + SIZE_W'(1) : '0;

    // zero pivot, acted on once the whole u row is stored
    assign piv_singular = (phase_reg == PH_U) && !(j_reg + SIZE_W'(1) < n_reg)
                        && piv_zero_reg;

    assign b_data    = is_sol_b ? sol_rdata : mat_rdata;
    assign init_data = (phase_reg == PH_B) ? sol_rdata : mat_rdata;
    assign prod_next = a_reg * b_data;
    assign acc_sat   = sat_q(acc_reg);
    assign rem_sh    = {rem_reg, dvd_reg[DVD_W-1]};
    assign quo_s     = neg_reg ? -$signed({16'b0, quo_reg}) : $signed({16'b0, quo_reg});
    assign quo_sat   = sat_q(quo_s);

    // row and column of the matrix access
    always_comb begin
        row_sel = '0;
        col_sel = '0;
        case (state_reg)
            S_INIT, S_FIN, S_DWR: begin
                case (phase_reg)
                    PH_U:    begin row_sel = i_reg; col_sel = j_reg; end
                    PH_L:    begin row_sel = j_reg; col_sel = i_reg; end
                    PH_F:    begin row_sel = i_reg; col_sel = n_reg; end
                    default: begin row_sel = i_reg; col_sel = i_reg; end
                endcase
                if (state_reg == S_FIN && is_div) begin
                    row_sel = i_reg;
                    col_sel = i_reg;
                end
            end
            S_RDA: begin
                row_sel = (phase_reg == PH_L) ? j_reg : i_reg;
                col_sel = t_reg;
            end
            S_RDB: begin
                row_sel = t_reg;
                col_sel = (phase_reg == PH_L) ? i_reg : j_reg;
            end
            default: ;
        endcase
    end

    assign addr_calc = (2*SIZE_W)'(row_sel) * (2*SIZE_W)'(n_reg + SIZE_W'(1))
                     + (2*SIZE_W)'(col_sel);
    assign mat_addr  = (state_reg == S_LOAD) ? load_cnt_reg[MAT_AW-1:0]
                                             : addr_calc[MAT_AW-1:0];
    assign mat_we    = (accept && ((2*SIZE_W)'(load_cnt_reg) < total))
                     || (state_reg == S_FIN && !is_div && !is_sol_b)
                     || (state_reg == S_DWR && phase_reg == PH_L);
    assign mat_wdata = (state_reg == S_LOAD) ? s_coefficient
                     : (state_reg == S_DWR) ? quo_sat[31:0] : acc_sat[31:0];

    always_comb begin
        case (state_reg)
            S_RDB:   sol_addr = t_reg[SOL_AW-1:0];
            S_ORD:   sol_addr = oi_reg;
            default: sol_addr = i_reg[SOL_AW-1:0];
        endcase
    end
    assign sol_we    = (state_reg == S_FIN && phase_reg == PH_F)
                     || (state_reg == S_DWR && phase_reg == PH_B);
    assign sol_wdata = (state_reg == S_DWR) ? quo_sat[31:0] : acc_sat[31:0];

    lus_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH)) u_mat_ram (
        .aclk  (aclk),
        .we    (mat_we),
        .waddr (mat_addr),
        .wdata (mat_wdata),
        .raddr (mat_addr),
        .rdata (mat_rdata)
    );

    lus_ram #(.WIDTH(32), .DEPTH(MAX_UNKNOWNS)) u_sol_ram (
        .aclk  (aclk),
        .we    (sol_we),
        .waddr (sol_addr),
        .wdata (sol_wdata),
        .raddr (sol_addr),
        .rdata (sol_rdata)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_LOAD:  if (accept && s_last_entry) state_next = S_INIT;
            S_INIT:  state_next = S_INITW;
            S_INITW: state_next = (tlo < thi) ? S_RDA : S_FIN;
            S_RDA:   state_next = S_RDB;
            S_RDB:   state_next = S_MUL;
            S_MUL:   state_next = S_ACC;
            S_ACC:   state_next = (t_reg + SIZE_W'(1) < thi) ? S_RDA : S_FIN;
            S_FIN:   state_next = is_div ? S_PIV : S_NEXT;
            S_PIV:   state_next = S_DIV;
            S_DIV:   if (dcnt_reg == DCNT_W'(DVD_W - 1)) state_next = S_DWR;
            S_DWR:   state_next = S_NEXT;
            S_NEXT: begin
                if (piv_singular) begin
                    state_next = S_OHOLD;
                end else begin
                    state_next = (phase_reg == PH_B && i_reg == '0) ? S_ORD : S_INIT;
                end
            end
            S_ORD:   state_next = S_OWAIT;
            S_OWAIT: state_next = S_OHOLD;
            S_OHOLD: begin
                if (m_ready) state_next = out_last_reg ? S_LOAD : S_ORD;
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_LOAD;
            phase_reg     <= PH_U;
            size_reg      <= SIZE_W'(SIZE_RESET);
            load_cnt_reg  <= '0;
            sat_reg       <= 1'b0;
            piv_zero_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) size_reg <= cfg_wr_data[SIZE_W-1:0];
            case (state_reg)
                S_LOAD: begin
                    if (accept) begin
                        if (s_last_entry) begin
                            load_cnt_reg <= '0;
                            n_reg        <= act_size;
                            sat_reg      <= 1'b0;
                            phase_reg    <= PH_U;
                            i_reg        <= '0;
                            j_reg        <= '0;
                        end else if ((2*SIZE_W)'(load_cnt_reg) < total) begin
                            load_cnt_reg <= load_cnt_reg + 1'b1;
                        end
                    end
                end
                S_INIT:  t_reg <= tlo;
                S_INITW: acc_reg <= 64'(init_data);
                S_RDB:   a_reg <= mat_rdata;
                S_MUL:   prod_reg <= prod_next;
                S_ACC: begin
                    acc_reg <= acc_reg - round_q(prod_reg);
                    t_reg   <= t_reg + SIZE_W'(1);
                end
                S_FIN: begin
                    val_reg <= acc_sat[31:0];
                    if (acc_sat[32]) sat_reg <= 1'b1;
                    if (phase_reg == PH_U && j_reg == i_reg) begin
                        piv_zero_reg <= (acc_sat[31:0] == '0);
                    end
                end
                S_PIV: begin
                    dmag_reg <= mat_rdata[31] ? 32'(-mat_rdata) : mat_rdata;
                    neg_reg  <= mat_rdata[31] ^ val_reg[31];
                    dvd_reg  <= {(val_reg[31] ? 32'(-val_reg) : 32'(val_reg)),
                                 FRACTION_BITS'(0)};
                    rem_reg  <= '0;
                    quo_reg  <= '0;
                    dcnt_reg <= '0;
                end
                S_DIV: begin
                    if (rem_sh >= {1'b0, dmag_reg}) begin
                        rem_reg <= 32'(rem_sh - {1'b0, dmag_reg});
                        quo_reg <= {quo_reg[DVD_W-2:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh[31:0];
                        quo_reg <= {quo_reg[DVD_W-2:0], 1'b0};
                    end
                    dvd_reg  <= {dvd_reg[DVD_W-2:0], 1'b0};
                    dcnt_reg <= dcnt_reg + 1'b1;
                end
                S_DWR: if (quo_sat[32]) sat_reg <= 1'b1;
                S_NEXT: begin
                    if (piv_singular) begin
                        out_value_reg  <= '0;
                        out_index_reg  <= '0;
                        out_status_reg <= ST_SINGULAR;
                        out_last_reg   <= 1'b1;
                        out_valid_reg  <= 1'b1;
                    end
                    case (phase_reg)
                        PH_U: begin
                            if (j_reg + SIZE_W'(1) < n_reg) begin
                                j_reg <= j_reg + SIZE_W'(1);
                            end else if (i_reg + SIZE_W'(1) < n_reg) begin
                                phase_reg <= PH_L;
                                j_reg     <= i_reg + SIZE_W'(1);
                            end else begin
                                phase_reg <= PH_F;
                                i_reg     <= '0;
                            end
                        end
                        PH_L: begin
                            if (j_reg + SIZE_W'(1) < n_reg) begin
                                j_reg <= j_reg + SIZE_W'(1);
                            end else begin
                                phase_reg <= PH_U;
                                i_reg     <= i_reg + SIZE_W'(1);
                                j_reg     <= i_reg + SIZE_W'(1);
                            end
                        end
                        PH_F: begin
                            if (i_reg + SIZE_W'(1) < n_reg) begin
                                i_reg <= i_reg + SIZE_W'(1);
                            end else begin
                                phase_reg <= PH_B;
                                i_reg     <= n_reg - SIZE_W'(1);
                            end
                        end
                        default: begin
                            if (i_reg == '0) oi_reg <= '0;
                            else i_reg <= i_reg - SIZE_W'(1);
                        end
                    endcase
                end
                S_OWAIT: begin
                    out_value_reg  <= sol_rdata;
                    out_index_reg  <= 4'(oi_reg);
                    out_status_reg <= sat_reg ? ST_SATURATE : ST_OK;
                    out_last_reg   <= (SIZE_W'(oi_reg) == n_reg - SIZE_W'(1));
                    out_valid_reg  <= 1'b1;
                end
                S_OHOLD: begin
                    if (m_ready) begin
                        out_valid_reg <= 1'b0;
                        oi_reg        <= oi_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_solution_value = out_value_reg;
    assign m_solution_index = out_index_reg;
    assign m_status         = out_status_reg;
    assign m_last_result    = out_last_reg;

    `ASSERT_SAME(a_ready_excl, m_valid, !s_ready)
    `ASSERT_SAME(a_singular_last, m_valid && m_status == ST_SINGULAR, m_last_result && m_solution_index == '0)
    `ASSERT_SAME(a_load_bound, 1'b1, load_cnt_reg <= CNT_W'(STORE_DEPTH))
    `ASSERT_NEXT(a_back_to_load, m_valid && m_ready && m_last_result, s_ready && !m_valid)

endmodule

// File: src/lus_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module lus_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
